[hw/rtl/aenc_pkg.sv]
// Shared types and constants for the arithmetic encoder step block.
package aenc_pkg;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_FREQ  = 2'd1,
    ST_TOTAL_BIG = 2'd2,
    ST_PEND_OVF  = 2'd3
  } status_t;

  typedef enum logic [0:0] {
    MODE_SYMBOL = 1'b0,
    MODE_FINISH = 1'b1
  } mode_t;

  localparam int unsigned FREQ_W = 31;
  localparam int unsigned PEND_W = 31;
  localparam logic [PEND_W-1:0] PEND_MAX = {PEND_W{1'b1}};
  localparam logic [FREQ_W-1:0] TOTAL_RESET = 31'd65536;

endpackage

[hw/rtl/aenc_muldiv.sv]
// Iterative unit computing floor(x * r / t), one bit of r per cycle.
module aenc_muldiv #(
  parameter int unsigned SB = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [aenc_pkg::FREQ_W-1:0] x,
  input  logic [SB:0]                 r,
  input  logic [aenc_pkg::FREQ_W-1:0] t,
  output logic                        done,
  output logic [SB:0]                 q
);
  import aenc_pkg::*;

  localparam int unsigned CW = $clog2(SB + 2);

  logic              busy_r;
  logic [CW-1:0]     cnt_r;
  logic [SB:0]       r_r;
  logic [FREQ_W-1:0] x_r;
  logic [FREQ_W-1:0] t_r;
  logic [FREQ_W-1:0] rem_r;
  logic [SB:0]       q_r;
  logic [FREQ_W+1:0] sum;
  logic [FREQ_W+1:0] t1;
  logic [FREQ_W+1:0] t2;
  logic [FREQ_W-1:0] rem_nxt;
  logic [SB:0]       q_nxt;

  // Remainder stays below t and x never exceeds t, so one step adds at most 2 to q.
  always_comb begin
    sum = {rem_r, 1'b0} + (r_r[SB] ? {2'b00, x_r} : '0);
    t1  = {2'b00, t_r};
    t2  = {1'b0, t_r, 1'b0};
    if (sum >= t2) begin
      rem_nxt = FREQ_W'(sum - t2);
      q_nxt   = {q_r[SB-1:0], 1'b0} + (SB+1)'(2);
    end else if (sum >= t1) begin
      rem_nxt = FREQ_W'(sum - t1);
      q_nxt   = {q_r[SB-1:0], 1'b0} + (SB+1)'(1);
    end else begin
      rem_nxt = sum[FREQ_W-1:0];
      q_nxt   = {q_r[SB-1:0], 1'b0};
    end
  end

  assign done = busy_r && (cnt_r == CW'(1));
  assign q    = q_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(SB + 1);
    end else if (busy_r) begin
      cnt_r <= cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      r_r   <= r;
      x_r   <= x;
      t_r   <= t;
      rem_r <= '0;
      q_r   <= '0;
    end else if (busy_r) begin
      r_r   <= {r_r[SB-1:0], 1'b0};
      rem_r <= rem_nxt;
      q_r   <= q_nxt;
    end
  end

`ifndef SYNTH
  a_busy_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> cnt_r != '0) else $error("busy with zero count");
  a_done_ends: assert property (@(posedge clk) disable iff (!rst_n)
    done && !start |=> !busy_r) else $error("unit still busy after done");
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !start |-> rem_r < t_r || t_r == '0) else $error("remainder not below t");
`endif

endmodule

[hw/rtl/arithmetic_encoder_step.sv]
// Top level of the range arithmetic encoder step with its sequencer.
// Usage:
//   Input channel in_*: one item is a symbol (in_mode 0, cumulative
//   interval [in_sym_low, in_sym_high) of cfg total) or a finish (in_mode 1).
//   Output channel out_*: zero or more result items per input item, each a
//   code bit with its follow count; out_last marks the final one.
//   cfg_wr_en/cfg_wr_data write total_count; write it only while idle.
// Sequence:
//   A symbol runs two multiply-divide passes on one shared shift-subtract
//   unit, then shifts out the settled bits, then takes the underflow steps,
//   and last emits one result per settled bit. Finish items and items that
//   fail the input checks go straight to a single response. One item is in
//   work at a time; in_ready is low until the item is done and its last
//   result, if any, is loaded into the output register.
// Reset: range low 0, range high all ones, no pending bits, total 65536.
// A stalled receiver holds the output register and halts the emit step.
module arithmetic_encoder_step #(
  parameter int unsigned STATE_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic                        in_mode,
  input  logic [aenc_pkg::FREQ_W-1:0] in_sym_low,
  input  logic [aenc_pkg::FREQ_W-1:0] in_sym_high,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic                        out_out_bit,
  output logic [aenc_pkg::PEND_W-1:0] out_follow_count,
  output logic [1:0]                  out_status,
  output logic                        out_last,
  input  logic                        cfg_wr_en,
  input  logic [aenc_pkg::FREQ_W-1:0] cfg_wr_data
);
  import aenc_pkg::*;

  localparam int unsigned SB = STATE_BITS;
  localparam int unsigned NW = $clog2(SB + 1);
  localparam logic [63:0] LIM  = 64'hFFFF_FFFF_FFFF_FFFF >> SB;
  localparam logic [63:0] MINR = (64'd1 << (SB - 2)) + 64'd2;
  localparam logic [63:0] MAX_TOTAL = (LIM < MINR) ? LIM : MINR;
  localparam logic [SB-1:0] HALF = {1'b1, {(SB-1){1'b0}}};

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DIVL  = 7'b0000010,
    S_DIVH  = 7'b0000100,
    S_SHIFT = 7'b0001000,
    S_UNDER = 7'b0010000,
    S_EMIT  = 7'b0100000,
    S_RESP  = 7'b1000000
  } state_t;

  state_t            state_r;
  logic [FREQ_W-1:0] total_r;
  logic [SB-1:0]     rlo_r;
  logic [SB-1:0]     rhi_r;
  logic [PEND_W-1:0] pend_r;
  logic [PEND_W-1:0] wpend_r;
  logic [PEND_W-1:0] pend0_r;
  logic [SB-1:0]     lo_r;
  logic [SB-1:0]     hi_r;
  logic [SB-1:0]     lo0_r;
  logic [NW-1:0]     n_r;
  logic [NW-1:0]     k_r;
  logic [FREQ_W-1:0] sh_r;
  logic [SB:0]       ql_r;
  logic              resp_bit_r;
  status_t           resp_status_r;

  logic              out_valid_r;
  logic              out_bit_r;
  logic [PEND_W-1:0] out_follow_r;
  status_t           out_status_r;
  logic              out_last_r;

  logic              md_start;
  logic              md_done;
  logic [FREQ_W-1:0] md_x;
  logic [SB:0]       md_r;
  logic [SB:0]       md_q;
  logic              in_acc;
  logic              slot_free;
  logic              out_load;
  logic              sym_ok;
  status_t           chk_status;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign out_load  = slot_free && (state_r == S_EMIT || state_r == S_RESP);

  always_comb begin
    sym_ok     = 1'b0;
    chk_status = ST_OK;
    if (in_sym_low >= in_sym_high) begin
      chk_status = ST_BAD_FREQ;
    end else if ({33'd0, total_r} > MAX_TOTAL) begin
      chk_status = ST_TOTAL_BIG;
    end else if (in_sym_high > total_r) begin
      chk_status = ST_BAD_FREQ;
    end else begin
      sym_ok = 1'b1;
    end
  end

  assign md_start = (in_acc && in_mode == MODE_SYMBOL && sym_ok) ||
                    (state_r == S_DIVL && md_done);
  assign md_x = (state_r == S_IDLE) ? in_sym_low : sh_r;
  assign md_r = {1'b0, rhi_r} - {1'b0, rlo_r} + (SB+1)'(1);

  aenc_muldiv #(.SB(SB)) u_md (
    .clk   (clk),
    .rst_n (rst_n),
    .start (md_start),
    .x     (md_x),
    .r     (md_r),
    .t     (total_r),
    .done  (md_done),
    .q     (md_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= TOTAL_RESET;
      rlo_r       <= '0;
      rhi_r       <= '1;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        total_r <= cfg_wr_data;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            if (in_mode == MODE_FINISH) begin
              state_r <= S_RESP;
            end else if (sym_ok) begin
              state_r <= S_DIVL;
            end else begin
              state_r <= S_RESP;
            end
          end
        end
        S_DIVL: if (md_done) state_r <= S_DIVH;
        S_DIVH: if (md_done) state_r <= S_SHIFT;
        S_SHIFT: begin
          if (!(lo_r[SB-1] == hi_r[SB-1] && n_r < NW'(SB))) begin
            state_r <= S_UNDER;
          end
        end
        S_UNDER: begin
          if (lo_r[SB-2] && !hi_r[SB-2]) begin
            if (wpend_r == PEND_MAX) begin
              state_r <= S_RESP;
            end
          end else begin
            rlo_r  <= lo_r;
            rhi_r  <= hi_r;
            pend_r <= wpend_r;
            state_r <= (n_r != '0) ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (slot_free && k_r == n_r - NW'(1)) begin
            state_r <= S_IDLE;
          end
        end
        S_RESP: begin
          if (slot_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Datapath registers; the emitted bits are the top n bits of the narrowed low bound.
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        sh_r    <= in_sym_high;
        pend0_r <= pend_r;
        if (in_mode == MODE_FINISH) begin
          resp_bit_r    <= 1'b1;
          resp_status_r <= ST_OK;
        end else begin
          resp_bit_r    <= 1'b0;
          resp_status_r <= chk_status;
        end
      end
      S_DIVL: if (md_done) ql_r <= md_q;
      S_DIVH: begin
        if (md_done) begin
          lo_r    <= rlo_r + ql_r[SB-1:0];
          lo0_r   <= rlo_r + ql_r[SB-1:0];
          hi_r    <= rlo_r + md_q[SB-1:0] - SB'(1);
          n_r     <= '0;
          k_r     <= '0;
          wpend_r <= pend_r;
        end
      end
      S_SHIFT: begin
        if (lo_r[SB-1] == hi_r[SB-1] && n_r < NW'(SB)) begin
          n_r     <= n_r + NW'(1);
          lo_r    <= {lo_r[SB-2:0], 1'b0};
          hi_r    <= {hi_r[SB-2:0], 1'b1};
          wpend_r <= '0;
        end
      end
      S_UNDER: begin
        if (lo_r[SB-2] && !hi_r[SB-2]) begin
          if (wpend_r == PEND_MAX) begin
            resp_bit_r    <= 1'b0;
            resp_status_r <= ST_PEND_OVF;
          end else begin
            wpend_r <= wpend_r + PEND_W'(1);
            lo_r    <= {lo_r[SB-2:0], 1'b0} ^ HALF;
            hi_r    <= {hi_r[SB-2:0] ^ HALF[SB-2:0], 1'b0} | HALF | SB'(1);
          end
        end
      end
      S_EMIT: begin
        if (slot_free) begin
          out_bit_r    <= lo0_r[SB-1];
          out_follow_r <= (k_r == '0) ? pend0_r : '0;
          out_status_r <= ST_OK;
          out_last_r   <= (k_r == n_r - NW'(1));
          lo0_r        <= {lo0_r[SB-2:0], 1'b0};
          k_r          <= k_r + NW'(1);
        end
      end
      S_RESP: begin
        if (slot_free) begin
          out_bit_r    <= resp_bit_r;
          out_follow_r <= '0;
          out_status_r <= resp_status_r;
          out_last_r   <= 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_out_bit      = out_bit_r;
  assign out_follow_count = out_follow_r;
  assign out_status       = out_status_r;
  assign out_last         = out_last_r;

`ifndef SYNTH
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last) else $error("error item not last");
  a_acc_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("ready right after accept");
  a_done_div: assert property (@(posedge clk) disable iff (!rst_n)
    md_done |-> state_r == S_DIVL || state_r == S_DIVH)
    else $error("divide done outside divide states");
  a_emit_count: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_EMIT |-> n_r != '0 && k_r < n_r) else $error("emit index out of range");
`endif

endmodule
